// ===== hdl/kspl_pkg.sv =====
// Package for the keyboard scancode pulse link: word types, action and
// register codes, reset values of the timing registers. No dependencies.
package kspl_pkg;

	localparam int CODE_BITS_DEF = 9;
	localparam int REG_W = 16;
	localparam int TIME_W = 32;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		ACT_ACK_LOW  = 2'd0,
		ACT_ACK_HIGH = 2'd1,
		ACT_LOAD     = 2'd2,
		ACT_SAMPLE   = 2'd3
	} action_t;

	localparam logic [CFG_IDX_W-1:0] REG_START_LEN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_LEN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_LEN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_LEN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_MIN_LEN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_MIN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_MAX   = 3'd6;

	localparam logic [REG_W-1:0] START_LEN_RST   = 16'd100;
	localparam logic [REG_W-1:0] ONE_LEN_RST     = 16'd56;
	localparam logic [REG_W-1:0] ZERO_LEN_RST    = 16'd38;
	localparam logic [REG_W-1:0] GAP_LEN_RST     = 16'd80;
	localparam logic [REG_W-1:0] ACK_MIN_LEN_RST = 16'd96;
	localparam logic [REG_W-1:0] LOWER_MIN_RST   = 16'd1696;
	localparam logic [REG_W-1:0] UPPER_MAX_RST   = 16'd2296;

	typedef struct packed {
		action_t           action;
		logic [TIME_W-1:0] now;
		logic [8:0]        scancode;
		logic              edge_select_in;
		logic              caps_in;
	} in_word_t;

	typedef struct packed {
		logic cp1_level;
		logic cp1_flag;
		logic edge_select_out;
		logic data_ready_set;
		logic caps_lock;
		logic caps_decided;
	} out_word_t;

	typedef struct packed {
		logic [REG_W-1:0] start_len;
		logic [REG_W-1:0] one_len;
		logic [REG_W-1:0] zero_len;
		logic [REG_W-1:0] gap_len;
	} seg_len_t;

	typedef struct packed {
		logic done;
		logic level;
	} walk_rsp_t;

endpackage

// ===== hdl/keyboard_scancode_pulse_link.sv =====
// Top level of the keyboard scancode pulse link: link state, timing
// registers, action sequencer and output word. Uses kspl_pkg, kspl_walk.
//
// channel  | signals                       | dir | notes
// in       | in_valid, in_ready, in_data   | in  | one action word
// out      | out_valid, out_ready, out_data| out | one result per action word
// cfg      | cfg_we, cfg_idx, cfg_data     | in  | register write, no wait
//
// An action word is decoded combinationally and registered in the output
// register; a sample during a send first runs the walker (one segment
// boundary per cycle, then the done register).
// Reset clears link state and loads the timing register defaults.
// in_ready is low from acceptance until the result word is taken.
module keyboard_scancode_pulse_link #(
	parameter int CODE_BITS = kspl_pkg::CODE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  kspl_pkg::in_word_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output kspl_pkg::out_word_t            out_data,
	input  logic                           cfg_we,
	input  logic [kspl_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [kspl_pkg::REG_W-1:0]     cfg_data
);
	import kspl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t            state_q;
	seg_len_t          lens_q;
	logic [REG_W-1:0]  ack_min_q;
	logic [REG_W-1:0]  lower_min_q;
	logic [REG_W-1:0]  upper_max_q;

	logic                 sending_q;
	logic                 timing_valid_q;
	logic [TIME_W-1:0]    start_time_q;
	logic [CODE_BITS-1:0] code_held_q;
	logic                 line_q;
	out_word_t            out_q;

	logic              accept;
	logic [TIME_W-1:0] elapsed;
	logic              walk_start;
	walk_rsp_t         walk_rsp;

	logic              nxt_sending;
	logic              nxt_valid;
	logic              nxt_line;
	logic              nxt_edge;
	logic              nxt_caps;
	logic              nxt_decided;
	logic              nxt_ready;
	logic              clr_start;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data = out_q;
	assign elapsed = in_data.now - start_time_q;

	always_comb begin
		nxt_sending = sending_q;
		nxt_valid = timing_valid_q;
		nxt_line = line_q;
		nxt_edge = in_data.edge_select_in;
		nxt_caps = in_data.caps_in;
		nxt_decided = 1'b0;
		nxt_ready = 1'b0;
		clr_start = 1'b0;
		walk_start = 1'b0;
		unique case (in_data.action)
			ACT_ACK_LOW: begin
				if (!timing_valid_q) begin
					nxt_valid = 1'b1;
					nxt_line = 1'b0;
				end
			end
			ACT_ACK_HIGH: begin
				if (!sending_q && timing_valid_q
						&& elapsed > TIME_W'(ack_min_q)) begin
					nxt_caps = (elapsed < TIME_W'(lower_min_q))
						|| (elapsed > TIME_W'(upper_max_q));
					nxt_decided = 1'b1;
				end
				nxt_sending = 1'b0;
				nxt_valid = 1'b0;
				clr_start = 1'b1;
				nxt_edge = 1'b0;
				nxt_line = 1'b1;
			end
			ACT_LOAD: begin
				nxt_sending = 1'b1;
				nxt_valid = 1'b0;
				clr_start = 1'b1;
				nxt_edge = 1'b1;
				nxt_ready = 1'b1;
				nxt_line = 1'b1;
			end
			default: begin
				if (timing_valid_q) begin
					if (!sending_q) begin
						nxt_line = 1'b0;
					end else begin
						walk_start = accept;
					end
				end
			end
		endcase
	end

	kspl_walk #(
		.CODE_BITS(CODE_BITS)
	) u_walk (
		.clk(clk),
		.arst_n(arst_n),
		.start(walk_start),
		.elapsed(elapsed),
		.code(code_held_q),
		.lens(lens_q),
		.rsp(walk_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lens_q.start_len <= START_LEN_RST;
			lens_q.one_len <= ONE_LEN_RST;
			lens_q.zero_len <= ZERO_LEN_RST;
			lens_q.gap_len <= GAP_LEN_RST;
			ack_min_q <= ACK_MIN_LEN_RST;
			lower_min_q <= LOWER_MIN_RST;
			upper_max_q <= UPPER_MAX_RST;
			sending_q <= 1'b0;
			timing_valid_q <= 1'b0;
			start_time_q <= '0;
			line_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_START_LEN:   lens_q.start_len <= cfg_data;
					REG_ONE_LEN:     lens_q.one_len <= cfg_data;
					REG_ZERO_LEN:    lens_q.zero_len <= cfg_data;
					REG_GAP_LEN:     lens_q.gap_len <= cfg_data;
					REG_ACK_MIN_LEN: ack_min_q <= cfg_data;
					REG_LOWER_MIN:   lower_min_q <= cfg_data;
					REG_UPPER_MAX:   upper_max_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sending_q <= nxt_sending;
						timing_valid_q <= nxt_valid;
						line_q <= nxt_line;
						if (clr_start) begin
							start_time_q <= '0;
						end else if (in_data.action == ACT_ACK_LOW && !timing_valid_q) begin
							start_time_q <= in_data.now;
						end
						state_q <= walk_start ? ST_WALK : ST_OUT;
					end
				end
				ST_WALK: begin
					if (walk_rsp.done) begin
						line_q <= walk_rsp.level;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (in_data.action == ACT_LOAD) begin
				code_held_q <= CODE_BITS'(in_data.scancode);
			end
			out_q.cp1_level <= nxt_line;
			out_q.cp1_flag <= (nxt_line == nxt_edge);
			out_q.edge_select_out <= nxt_edge;
			out_q.data_ready_set <= nxt_ready;
			out_q.caps_lock <= nxt_caps;
			out_q.caps_decided <= nxt_decided;
		end else if (state_q == ST_WALK && walk_rsp.done) begin
			out_q.cp1_level <= walk_rsp.level;
			out_q.cp1_flag <= (walk_rsp.level == out_q.edge_select_out);
		end
	end

	a_ready_vs_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output sides open together");

	a_walk_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		walk_start |=> !in_ready && !out_valid)
		else $error("walker started but sequencer left the walk state");

	a_load_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.data_ready_set |->
			out_data.cp1_level && out_data.edge_select_out && !sending_q == 1'b0)
		else $error("load word inconsistent with link state");

	a_caps_on_ack_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.caps_decided |->
			!out_data.edge_select_out && out_data.cp1_level && !timing_valid_q)
		else $error("caps decided outside an ack-high word");

endmodule

// ===== hdl/kspl_walk.sv =====
// Timeline walker: one adder and one compare step through the segment
// boundaries, one boundary a cycle. Depends on kspl_pkg.
module kspl_walk #(
	parameter int CODE_BITS = kspl_pkg::CODE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [kspl_pkg::TIME_W-1:0] elapsed,
	input  logic [CODE_BITS-1:0]        code,
	input  kspl_pkg::seg_len_t          lens,
	output kspl_pkg::walk_rsp_t         rsp
);
	import kspl_pkg::*;

	localparam int STEP_W = $clog2(2 * CODE_BITS + 1);
	localparam int POS_W = REG_W + STEP_W;
	localparam int BIT_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * CODE_BITS);

	logic              busy_q;
	logic              done_q;
	logic              level_q;
	logic [TIME_W-1:0] t_q;
	logic [POS_W-1:0]  pos_q;
	logic [STEP_W-1:0] step_q;

	logic [STEP_W-1:0] idx_full;
	logic [BIT_W-1:0]  bit_idx;
	logic [REG_W-1:0]  addend;
	logic [POS_W-1:0]  sum;
	logic              hit;

	always_comb begin
		idx_full = STEP_W'(CODE_BITS - 1) - ((step_q - STEP_W'(1)) >> 1);
		bit_idx = idx_full[BIT_W-1:0];
		if (step_q == '0) begin
			addend = lens.start_len;
		end else if (step_q[0]) begin
			addend = code[bit_idx] ? lens.one_len : lens.zero_len;
		end else begin
			addend = lens.gap_len;
		end
		sum = pos_q + POS_W'(addend);
		hit = t_q < TIME_W'(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			level_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (hit || step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					level_q <= hit & step_q[0];
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			t_q <= elapsed;
			pos_q <= '0;
		end else if (busy_q) begin
			pos_q <= sum;
		end
	end

	assign rsp.done = done_q;
	assign rsp.level = level_q;

endmodule

// ===== tb/sv/tb_keyboard_scancode_pulse_link.sv =====
// Testbench for keyboard_scancode_pulse_link: queued action words, a predictor
// of the CP1 line and caps decision, and a result checker with random stalls.
// Depends on kspl_pkg and the keyboard_scancode_pulse_link RTL only.
module tb_keyboard_scancode_pulse_link;
	import kspl_pkg::*;

	localparam int CODE_BITS = CODE_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 315;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [REG_W-1:0] cfg_data = '0;

	keyboard_scancode_pulse_link dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	in_word_t action_words [$];
	out_word_t due_results [$];
	int queued_words = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	logic steady = 1'b0;

	// predictor copy of registers and link state
	logic [REG_W-1:0] link_regs [7] = '{START_LEN_RST, ONE_LEN_RST, ZERO_LEN_RST,
		GAP_LEN_RST, ACK_MIN_LEN_RST, LOWER_MIN_RST, UPPER_MAX_RST};
	logic code_sending = 1'b0;
	logic timing_armed = 1'b0;
	logic [TIME_W-1:0] ack_start = '0;
	logic [CODE_BITS-1:0] code_latched = '0;
	logic line_now = 1'b1;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic timeline_line(logic [TIME_W-1:0] elapsed);
		longint unsigned mark;
		mark = link_regs[REG_START_LEN];
		if (elapsed < mark)
			return 1'b0;
		for (int b = CODE_BITS - 1; b >= 0; b--) begin
			mark += code_latched[b] ? link_regs[REG_ONE_LEN] : link_regs[REG_ZERO_LEN];
			if (elapsed < mark)
				return 1'b1;
			mark += link_regs[REG_GAP_LEN];
			if (elapsed < mark)
				return 1'b0;
		end
		return 1'b0;
	endfunction

	function automatic out_word_t predict_link_word(in_word_t w);
		out_word_t r;
		logic [TIME_W-1:0] elapsed;
		logic edge_sel, caps, ready, decided;
		edge_sel = w.edge_select_in;
		caps = w.caps_in;
		ready = 1'b0;
		decided = 1'b0;
		elapsed = w.now - ack_start;
		case (w.action)
			ACT_ACK_LOW: begin
				if (!timing_armed) begin
					ack_start = w.now;
					timing_armed = 1'b1;
					line_now = 1'b0;
				end
			end
			ACT_ACK_HIGH: begin
				if (!code_sending && timing_armed
						&& elapsed > TIME_W'(link_regs[REG_ACK_MIN_LEN])) begin
					caps = (elapsed < TIME_W'(link_regs[REG_LOWER_MIN])
						|| elapsed > TIME_W'(link_regs[REG_UPPER_MAX]));
					decided = 1'b1;
				end
				code_sending = 1'b0;
				timing_armed = 1'b0;
				ack_start = '0;
				edge_sel = 1'b0;
				line_now = 1'b1;
			end
			ACT_LOAD: begin
				code_latched = w.scancode[CODE_BITS-1:0];
				code_sending = 1'b1;
				timing_armed = 1'b0;
				ack_start = '0;
				edge_sel = 1'b1;
				ready = 1'b1;
				line_now = 1'b1;
			end
			default: begin
				if (timing_armed)
					line_now = code_sending ? timeline_line(elapsed) : 1'b0;
			end
		endcase
		r.cp1_level = line_now;
		r.cp1_flag = (line_now == edge_sel);
		r.edge_select_out = edge_sel;
		r.data_ready_set = ready;
		r.caps_lock = caps;
		r.caps_decided = decided;
		return r;
	endfunction

	// word driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				due_results.push_back(predict_link_word(in_data));
			if (!in_valid || in_ready) begin
				if (action_words.size() > 0 && (steady || $urandom_range(99) >= 22)) begin
					in_valid <= 1'b1;
					in_data <= action_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result checker
	always @(posedge clk) begin : result_check
		out_word_t due;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result word %b", out_data);
				end else begin
					due = due_results.pop_front();
					if (out_data.cp1_level !== due.cp1_level
							|| out_data.cp1_flag !== due.cp1_flag
							|| out_data.edge_select_out !== due.edge_select_out
							|| out_data.data_ready_set !== due.data_ready_set
							|| out_data.caps_lock !== due.caps_lock
							|| out_data.caps_decided !== due.caps_decided) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"mismatch: exp lvl=%b flag=%b esel=%b rdy=%b caps=%b dec=%b",
								" got lvl=%b flag=%b esel=%b rdy=%b caps=%b dec=%b"},
								due.cp1_level, due.cp1_flag, due.edge_select_out,
								due.data_ready_set, due.caps_lock, due.caps_decided,
								out_data.cp1_level, out_data.cp1_flag,
								out_data.edge_select_out, out_data.data_ready_set,
								out_data.caps_lock, out_data.caps_decided);
					end
				end
			end
			out_ready <= steady || ($urandom_range(99) >= 22);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void queue_word(action_t act, logic [TIME_W-1:0] at, logic [8:0] code);
		in_word_t w;
		w.action = act;
		w.now = at;
		w.scancode = code;
		w.edge_select_in = 1'($urandom);
		w.caps_in = 1'($urandom);
		action_words.push_back(w);
		queued_words++;
	endfunction

	task automatic wait_drained();
		while (action_words.size() > 0 || in_valid || due_results.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		link_regs[idx] = val;
	endtask

	task automatic set_timing(logic [REG_W-1:0] s, logic [REG_W-1:0] o, logic [REG_W-1:0] z,
			logic [REG_W-1:0] g, logic [REG_W-1:0] a, logic [REG_W-1:0] lo,
			logic [REG_W-1:0] hi);
		write_reg(REG_START_LEN, s);
		write_reg(REG_ONE_LEN, o);
		write_reg(REG_ZERO_LEN, z);
		write_reg(REG_GAP_LEN, g);
		write_reg(REG_ACK_MIN_LEN, a);
		write_reg(REG_LOWER_MIN, lo);
		write_reg(REG_UPPER_MAX, hi);
	endtask

	// load, ack low, samples around segment edges and at random, ack high; either ack may be left out
	function automatic void queue_scancode_exchange();
		logic [8:0] code;
		logic [TIME_W-1:0] t0, e, run;
		logic [TIME_W-1:0] marks [2*CODE_BITS+1];
		case ($urandom_range(7))
			0: code = '0;
			1: code = '1;
			default: code = 9'($urandom);
		endcase
		run = link_regs[REG_START_LEN];
		marks[0] = run;
		for (int b = CODE_BITS - 1; b >= 0; b--) begin
			run += code[b] ? link_regs[REG_ONE_LEN] : link_regs[REG_ZERO_LEN];
			marks[2*(CODE_BITS-1-b)+1] = run;
			run += link_regs[REG_GAP_LEN];
			marks[2*(CODE_BITS-1-b)+2] = run;
		end
		t0 = $urandom;
		queue_word(ACT_LOAD, $urandom, code);
		if ($urandom_range(9) != 0) begin
			queue_word(ACT_ACK_LOW, t0, 9'($urandom));
			repeat ($urandom_range(8, 2)) begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4: e = marks[$urandom_range(2*CODE_BITS)]
						+ $urandom_range(2) - 1;
					5, 6, 7: e = $urandom_range(run + 16);
					default: e = $urandom;
				endcase
				queue_word(ACT_SAMPLE, t0 + e, 9'($urandom));
			end
		end
		if ($urandom_range(9) != 0)
			queue_word(ACT_ACK_HIGH, t0 + $urandom_range(run + 100), 9'($urandom));
	endfunction

	// ack low then ack high, with no code loaded here: caps timing
	function automatic void queue_caps_exchange();
		logic [TIME_W-1:0] t0, e;
		t0 = $urandom;
		queue_word(ACT_ACK_LOW, t0, 9'($urandom));
		repeat ($urandom_range(2)) begin
			if ($urandom_range(3) == 0)
				queue_word(ACT_ACK_LOW, $urandom, 9'($urandom));
			else
				queue_word(ACT_SAMPLE, $urandom, 9'($urandom));
		end
		case ($urandom_range(5))
			0: e = TIME_W'(link_regs[REG_ACK_MIN_LEN]) + $urandom_range(2) - 1;
			1: e = TIME_W'(link_regs[REG_LOWER_MIN]) + $urandom_range(2) - 1;
			2: e = TIME_W'(link_regs[REG_UPPER_MAX]) + $urandom_range(2) - 1;
			3, 4: e = $urandom_range(TIME_W'(link_regs[REG_UPPER_MAX]) + 600);
			default: e = $urandom;
		endcase
		queue_word(ACT_ACK_HIGH, t0 + e, 9'($urandom));
	endfunction

	initial begin
		int phase_start;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		queue_word(ACT_SAMPLE, 32'h0, 9'h000);
		queue_word(ACT_ACK_HIGH, 32'hFFFF_FFFF, 9'h1FF);
		queue_word(ACT_ACK_LOW, 32'hFFFF_FFF0, 9'h000);
		queue_word(ACT_ACK_LOW, 32'd5, 9'h1FF);          // ignored, timing running
		queue_word(ACT_SAMPLE, 32'h10, 9'h000);          // no code pending
		queue_word(ACT_ACK_HIGH, 32'd984, 9'h000);       // wraps, short hold
		queue_word(ACT_ACK_LOW, 32'd1000, 9'h000);
		queue_word(ACT_ACK_HIGH, 32'd3000, 9'h000);      // lower case window
		queue_word(ACT_ACK_LOW, 32'd0, 9'h000);
		queue_word(ACT_ACK_HIGH, 32'd2297, 9'h000);      // past upper bound
		queue_word(ACT_ACK_LOW, 32'd0, 9'h000);
		queue_word(ACT_ACK_HIGH, 32'd96, 9'h000);        // too short to decide
		queue_word(ACT_LOAD, 32'h1234, 9'h1FF);
		queue_word(ACT_SAMPLE, 32'h5000, 9'h000);        // no timing yet
		queue_word(ACT_ACK_LOW, 32'h100, 9'h000);
		queue_word(ACT_SAMPLE, 32'h100 + 32'd99, 9'h000);
		queue_word(ACT_SAMPLE, 32'h100 + 32'd100, 9'h000);
		queue_word(ACT_SAMPLE, 32'h100 + 32'd156, 9'h000);
		queue_word(ACT_SAMPLE, 32'hFFFF_0000, 9'h000);
		queue_word(ACT_ACK_HIGH, 32'h100 + 32'd1000, 9'h000); // code pending
		queue_word(ACT_LOAD, 32'h0, 9'h000);
		queue_word(ACT_ACK_LOW, 32'hFFFF_FFFF, 9'h000);
		queue_word(ACT_SAMPLE, 32'd99, 9'h000);
		queue_word(ACT_SAMPLE, 32'd137, 9'h000);
		queue_word(ACT_ACK_HIGH, 32'd500, 9'h000);

		for (int phase = 0; phase < 6; phase++) begin
			if (phase > 0) begin
				wait_drained();
				case (phase)
					1: set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
					2: set_timing('1, '1, '1, '1, '1, '1, '1);
					3: set_timing(16'($urandom_range(1, 400)), 16'($urandom_range(1, 200)),
						16'($urandom_range(1, 200)), 16'($urandom_range(1, 200)),
						16'($urandom_range(300)), 16'($urandom_range(3000)),
						16'($urandom_range(3000)));
					4: set_timing(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
						16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
						16'($urandom), 16'($urandom), 16'($urandom));
					default: set_timing(START_LEN_RST, ONE_LEN_RST, ZERO_LEN_RST,
						GAP_LEN_RST, ACK_MIN_LEN_RST, LOWER_MIN_RST, UPPER_MAX_RST);
				endcase
			end
			steady = (phase == 2);
			phase_start = queued_words;
			while (queued_words - phase_start < PHASE_WORDS) begin
				case ($urandom_range(19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9: queue_scancode_exchange();
					10, 11, 12, 13, 14, 15: queue_caps_exchange();
					default: repeat ($urandom_range(3, 1))
						queue_word(action_t'($urandom_range(3)), $urandom, 9'($urandom));
				endcase
			end
		end

		wait_drained();
		if (mismatch_count == 0 && due_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/kspl_pkg.sv
hdl/kspl_walk.sv
hdl/keyboard_scancode_pulse_link.sv
tb/sv/tb_keyboard_scancode_pulse_link.sv
